/* hw/rtl/wpm_pkg.sv */
`timescale 1ns / 1ps

package wpm_pkg;

  localparam int unsigned LenFieldW = 5;
  localparam int unsigned CfgWordW  = 64;

  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharAny  = 8'h3F;

  typedef enum logic [1:0] {
    CfgCharsLow  = 2'd0,
    CfgCharsHigh = 2'd1,
    CfgLength    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] name_char;
    logic       end_of_name;
    logic       empty_name;
  } in_item_t;

  typedef struct packed {
    logic matched;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          index;
    logic [CfgWordW-1:0] wdata;
  } cfg_item_t;

  // ascii lower case folds to upper case, everything else unchanged
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61 : 8'h7A]}) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/wpm_chan_if.sv */
`timescale 1ns / 1ps

interface wpm_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/wpm_cfg_regs.sv */
`timescale 1ns / 1ps

module wpm_cfg_regs import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wpm_chan_if.sink                    cfg_i,
  output logic [PATTERN_MAX-1:0][7:0] pat_char_o,
  output logic [PATTERN_MAX-1:0]      pat_star_o,
  output logic [PATTERN_MAX-1:0]      pat_any_o,
  output logic [PATTERN_MAX:0]        empty_row_o,
  output logic [LenW-1:0]             len_o,
  output logic                        cfg_wr_o
);

  logic [PATTERN_MAX-1:0][7:0] char_q;
  logic [PATTERN_MAX-1:0]      star_q;
  logic [PATTERN_MAX-1:0]      any_q;
  logic [LenW-1:0]             len_q;
  logic                        cfg_fire;
  logic [LenFieldW-1:0]        len_field;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign len_field   = cfg_i.data.wdata[LenFieldW-1:0];

  // pattern bytes are kept folded with their wildcard flags beside them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
      star_q <= '0;
      any_q  <= '0;
      len_q  <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.data.index)
        CfgCharsLow: begin
          for (int k = 0; k < PATTERN_MAX && k < 8; k++) begin
            char_q[k] <= fold_char(cfg_i.data.wdata[8*k +: 8]);
            star_q[k] <= cfg_i.data.wdata[8*k +: 8] == CharStar;
            any_q[k]  <= cfg_i.data.wdata[8*k +: 8] == CharAny;
          end
        end
        CfgCharsHigh: begin
          for (int k = 8; k < PATTERN_MAX; k++) begin
            char_q[k] <= fold_char(cfg_i.data.wdata[8*(k-8) +: 8]);
            star_q[k] <= cfg_i.data.wdata[8*(k-8) +: 8] == CharStar;
            any_q[k]  <= cfg_i.data.wdata[8*(k-8) +: 8] == CharAny;
          end
        end
        CfgLength: begin
          if (len_field > LenFieldW'(PATTERN_MAX)) begin
            len_q <= LenW'(PATTERN_MAX);
          end else begin
            len_q <= len_field[LenW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // empty prefix row: bit j set while the first j pattern bytes are all stars
  always_comb begin
    logic acc;
    empty_row_o = '0;
    empty_row_o[0] = 1'b1;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      acc = 1'b1;
      for (int k = 0; k < j; k++) begin
        acc = acc & star_q[k];
      end
      empty_row_o[j] = acc;
    end
  end

  assign pat_char_o = char_q;
  assign pat_star_o = star_q;
  assign pat_any_o  = any_q;
  assign len_o      = len_q;
  assign cfg_wr_o   = cfg_fire &&
                      (cfg_i.data.index inside {CfgCharsLow, CfgCharsHigh, CfgLength});

endmodule

/* hw/rtl/wpm_core.sv */
`timescale 1ns / 1ps

module wpm_core import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wpm_chan_if.sink                    in_i,
  wpm_chan_if.source                  out_o,
  input  logic [PATTERN_MAX-1:0][7:0] pat_char_i,
  input  logic [PATTERN_MAX-1:0]      pat_star_i,
  input  logic [PATTERN_MAX-1:0]      pat_any_i,
  input  logic [PATTERN_MAX:0]        empty_row_i,
  input  logic [LenW-1:0]             len_i,
  input  logic                        cfg_wr_i
);

  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic [PATTERN_MAX:0] row_q;
  logic                 fresh_q;
  logic                 out_valid_q;
  logic                 out_matched_q;

  logic                 in_fire;
  logic                 s1_fire;
  logic                 has_res;
  logic                 out_free;
  logic [PATTERN_MAX:0] cur_row;
  logic [PATTERN_MAX:0] next_row;
  logic [PATTERN_MAX:0] res_row;
  logic                 res_bit;

  // fresh_q means the row is the empty prefix row of the current pattern
  assign cur_row  = fresh_q ? empty_row_i : row_q;
  assign has_res  = s1_item_q.end_of_name || s1_item_q.empty_name;
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!has_res || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  // star positions form a carry chain: next[j] = g[j] | p[j] & next[j-1],
  // resolved with a log-depth prefix network
  always_comb begin
    logic [7:0]           c;
    logic [PATTERN_MAX:0] g;
    logic [PATTERN_MAX:0] p;
    logic [PATTERN_MAX:0] g_n;
    logic [PATTERN_MAX:0] p_n;
    c = fold_char(s1_item_q.name_char);
    g = '0;
    p = '0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      p[j] = pat_star_i[j-1];
      if (pat_star_i[j-1]) begin
        g[j] = cur_row[j];
      end else begin
        g[j] = (pat_any_i[j-1] || pat_char_i[j-1] == c) && cur_row[j-1];
      end
    end
    for (int s = 1; s <= PATTERN_MAX; s = s * 2) begin
      g_n = g;
      p_n = p;
      for (int j = s; j <= PATTERN_MAX; j++) begin
        g_n[j] = g[j] | (p[j] & g[j-s]);
        p_n[j] = p[j] & p[j-s];
      end
      g = g_n;
      p = p_n;
    end
    next_row = g;
  end

  assign res_row = s1_item_q.empty_name ? empty_row_i : next_row;
  assign res_bit = (len_i == '0) || res_row[len_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else if (cfg_wr_i) begin
      fresh_q <= 1'b1;
    end else if (s1_fire) begin
      fresh_q <= has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && !has_res) begin
      row_q <= next_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_res) begin
      out_matched_q <= res_bit;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = '{matched: out_matched_q};

  a_empty_pattern_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && len_i == '0 |-> out_matched_q)
    else $error("empty pattern gave no match");

  a_row_fresh_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && has_res |=> fresh_q)
    else $error("row not reset after end of name");

  a_row_fresh_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> fresh_q)
    else $error("row not reset after register write");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && has_res && out_valid_q)
    else $error("input stalled without a waiting result");

endmodule

/* hw/rtl/wildcard_pattern_matcher_top.sv */
`timescale 1ns / 1ps

// channel  modport  payload     transaction
// in_i     sink     in_item_t   one name byte, or one empty-name marker
// out_o    source   out_item_t  match flag at the end of each name
// cfg_i    sink     cfg_item_t  register write, index and 64-bit data
//
// one name byte per cycle outside the input stall below; a result is offered
// after its end-of-name byte passes the input then the output register
// the row update is a single pass of a prefix network over the pattern
// positions between the input register and the row register
// reset leaves an empty pattern and a fresh row; there is no clearing pass
// input stalls only while a result waits on a full output register

module wildcard_pattern_matcher_top import wpm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpm_chan_if.sink    in_i,
  wpm_chan_if.source  out_o,
  wpm_chan_if.sink    cfg_i
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0] pat_char;
  logic [PATTERN_MAX-1:0]      pat_star;
  logic [PATTERN_MAX-1:0]      pat_any;
  logic [PATTERN_MAX:0]        empty_row;
  logic [LenW-1:0]             len;
  logic                        cfg_wr;

  wpm_cfg_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pat_char_o  (pat_char),
    .pat_star_o  (pat_star),
    .pat_any_o   (pat_any),
    .empty_row_o (empty_row),
    .len_o       (len),
    .cfg_wr_o    (cfg_wr)
  );

  wpm_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .pat_char_i  (pat_char),
    .pat_star_i  (pat_star),
    .pat_any_i   (pat_any),
    .empty_row_i (empty_row),
    .len_i       (len),
    .cfg_wr_i    (cfg_wr)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import wpm_pkg::*;

  localparam int unsigned PatMax       = 16;
  localparam logic [1:0]  CfgUnused    = 2'd3;
  localparam int unsigned RandItems    = 520;
  localparam int unsigned CalmItems    = 80;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;

  typedef struct {
    bit          is_write;
    logic [1:0]  idx;
    logic [63:0] wdata;
    in_item_t    it;
    bit          known;
    bit          want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  wpm_chan_if #(.payload_t(in_item_t))  name_if ();
  wpm_chan_if #(.payload_t(out_item_t)) match_if ();
  wpm_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  wildcard_pattern_matcher_top #(
    .PATTERN_MAX(PatMax)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (name_if),
    .out_o (match_if),
    .cfg_i (cfg_if)
  );

  // glob predictor state, mirrors the block registers
  logic [63:0] glob_lo;
  logic [63:0] glob_hi;
  logic [4:0]  glob_len;
  logic [16:0] glob_row;

  bit        match_q[$];
  plan_row_t plan[$];
  int errors;
  int n_items;
  int n_results;
  int n_writes;
  int n_phases;
  int stall_left;
  bit calm;

  function automatic void add_row(plan_row_t r);
    plan = {plan, r};
  endfunction

  function automatic int unsigned used_len();
    return (glob_len > PatMax) ? PatMax : int'(glob_len);
  endfunction

  function automatic logic [7:0] glob_byte(int unsigned k);
    return (k < 8) ? glob_lo[8*k +: 8] : glob_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // leading stars can already match the empty name
  function automatic logic [16:0] start_row();
    logic [16:0] r;
    r = 17'd1;
    for (int j = 1; j <= used_len(); j++) begin
      if (glob_byte(j - 1) != CharStar) break;
      r[j] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [16:0] advance(logic [16:0] r, logic [7:0] c);
    logic [16:0] nx;
    logic [7:0]  p;
    nx = '0;
    for (int j = 1; j <= used_len(); j++) begin
      p = glob_byte(j - 1);
      if (p == CharStar) begin
        nx[j] = nx[j-1] | r[j];
      end else if (p == CharAny || upcase(p) == upcase(c)) begin
        nx[j] = r[j-1];
      end
    end
    return nx;
  endfunction

  function automatic bit verdict(logic [16:0] r);
    return (used_len() == 0) ? 1'b1 : r[used_len()];
  endfunction

  // returns 1 when the transaction closes a name, m then holds the match flag
  function automatic bit glob_step(in_item_t it, output bit m);
    logic [16:0] r;
    m = 1'b0;
    if (it.empty_name) begin
      glob_row = start_row();
      m = verdict(glob_row);
      return 1'b1;
    end
    r = advance(glob_row, it.name_char);
    if (it.end_of_name) begin
      m = verdict(r);
      glob_row = start_row();
      return 1'b1;
    end
    glob_row = r;
    return 1'b0;
  endfunction

  function automatic void glob_write(logic [1:0] idx, logic [63:0] d);
    case (idx)
      CfgCharsLow:  glob_lo = d;
      CfgCharsHigh: glob_hi = d;
      CfgLength:    glob_len = d[4:0];
      default:      return;
    endcase
    glob_row = start_row();
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h41 + 8'($urandom_range(0, 25));
      3, 4:    return 8'h61 + 8'($urandom_range(0, 25));
      5:       return CharStar;
      6:       return CharAny;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic plan_row_t p_item(logic [7:0] c, bit eon, bit emp,
                                       bit known = 1'b0, bit want = 1'b0);
    plan_row_t r;
    r.is_write = 1'b0;
    r.idx      = '0;
    r.wdata    = '0;
    r.it       = in_item_t'{name_char: c, end_of_name: eon, empty_name: emp};
    r.known    = known;
    r.want     = want;
    return r;
  endfunction

  function automatic plan_row_t p_write(logic [1:0] idx, logic [63:0] d);
    plan_row_t r;
    r = p_item(8'h00, 1'b0, 1'b0);
    r.is_write = 1'b1;
    r.idx      = idx;
    r.wdata    = d;
    return r;
  endfunction

  task automatic send_item(in_item_t it, bit known = 1'b0, bit want = 1'b0);
    bit m;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      name_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    name_if.valid <= 1'b1;
    name_if.data  <= it;
    do @(posedge clk_i); while (!name_if.ready);
    n_items++;
    if (glob_step(it, m)) begin
      match_q = {match_q, known ? want : m};
    end
  endtask

  // only while idle: all results in and the last byte through the row register
  task automatic write_reg(logic [1:0] idx, logic [63:0] d);
    name_if.valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_item_t'{index: idx, wdata: d};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    glob_write(idx, d);
    n_writes++;
  endtask

  task automatic new_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lw;
    logic [7:0]  pb;
    logic [1:0]  idx;
    bit          all_star;
    int          first;
    all_star = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < 16; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: pb = CharStar;
        6, 7, 8:          pb = CharAny;
        default:          pb = rand_char();
      endcase
      if (all_star) pb = CharStar;
      if (k < 8) lo[8*k +: 8] = pb;
      else hi[8*(k-8) +: 8] = pb;
    end
    lw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       lw[4:0] = 5'd0;
      1, 2:    lw[4:0] = 5'(PatMax);
      3:       lw[4:0] = 5'($urandom_range(17, 31));
      default: lw[4:0] = 5'($urandom_range(1, 15));
    endcase
    first = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      idx = 2'((first + i) % 3);
      if ($urandom_range(0, 4) != 0) begin
        case (idx)
          CfgCharsLow:  write_reg(idx, lo);
          CfgCharsHigh: write_reg(idx, hi);
          default:      write_reg(idx, lw);
        endcase
      end
    end
    if ($urandom_range(0, 6) == 0) write_reg(CfgUnused, {$urandom, $urandom});
    n_phases++;
  endtask

  // clean names follow the pattern, noisy ones are random, cut ones never end
  task automatic send_name(bit mangle, bit noise, bit cut);
    logic [7:0] nm[$];
    logic [7:0] p;
    int         pos;
    if (noise) begin
      repeat ($urandom_range(1, 12)) nm = {nm, rand_char()};
    end else begin
      for (int k = 0; k < used_len(); k++) begin
        p = glob_byte(k);
        if (p == CharStar) begin
          repeat ($urandom_range(0, 3)) nm = {nm, rand_char()};
        end else if (p == CharAny) begin
          nm = {nm, rand_char()};
        end else if (((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A)) &&
                     $urandom_range(0, 1) == 1) begin
          nm = {nm, p ^ 8'h20};
        end else begin
          nm = {nm, p};
        end
      end
    end
    if (mangle) begin
      case ($urandom_range(0, 2))
        0: if (nm.size() != 0) begin
          pos = $urandom_range(0, nm.size() - 1);
          nm[pos] = rand_char();
        end
        1: if (nm.size() != 0) begin
          pos = $urandom_range(0, nm.size() - 1);
          nm.delete(pos);
        end
        default: nm = {nm, rand_char()};
      endcase
    end
    if (nm.size() == 0) begin
      send_item(in_item_t'{name_char: rand_char(), end_of_name: 1'($urandom_range(0, 1)),
                           empty_name: 1'b1});
      return;
    end
    for (int i = 0; i < nm.size(); i++) begin
      send_item(in_item_t'{name_char: nm[i], end_of_name: (i == nm.size() - 1) && !cut,
                           empty_name: 1'b0});
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    bit e;
    if (rst_ni && match_if.valid && match_if.ready) begin
      n_results++;
      if (match_q.size() == 0) begin
        errors++;
        $error("matched: expected no transaction, actual %0b", match_if.data.matched);
      end else begin
        e = match_q.pop_front();
        if (e !== match_if.data.matched) begin
          errors++;
          $error("matched: expected %0b, actual %0b", e, match_if.data.matched);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      match_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      match_if.ready <= 1'b0;
    end else begin
      match_if.ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int        start_items;
    int        kind;

    rst_ni         = 1'b0;
    name_if.valid  = 1'b0;
    name_if.data   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    match_if.ready = 1'b0;
    glob_lo        = '0;
    glob_hi        = '0;
    glob_len       = '0;
    glob_row       = start_row();
    errors         = 0;
    n_items        = 0;
    n_results      = 0;
    n_writes       = 0;
    n_phases       = 0;
    stall_left     = 0;
    calm           = 1'b0;

    // empty pattern after reset matches anything
    add_row(p_item(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1));
    add_row(p_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b1));
    add_row(p_item(8'h7A, 1'b0, 1'b0));
    add_row(p_item(8'h80, 1'b1, 1'b0));
    // pattern "a?*Z", upper length bits must be ignored
    add_row(p_write(CfgCharsLow, 64'h0000_0000_5A2A_3F61));
    add_row(p_write(CfgLength, 64'hFFFF_FFFF_FFFF_FFE4));
    add_row(p_item(8'h41, 1'b0, 1'b0));
    add_row(p_item(8'h78, 1'b0, 1'b0));
    add_row(p_item(8'h71, 1'b0, 1'b0));
    add_row(p_item(8'h7A, 1'b1, 1'b0));
    add_row(p_item(8'h61, 1'b0, 1'b0));
    add_row(p_item(8'h3F, 1'b0, 1'b0));
    add_row(p_item(8'h5A, 1'b1, 1'b0));
    add_row(p_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    // empty flag wins over end of name and drops the partial name
    add_row(p_item(8'h61, 1'b0, 1'b0));
    add_row(p_item(8'h61, 1'b1, 1'b1, 1'b1, 1'b0));
    add_row(p_item(8'h62, 1'b1, 1'b0, 1'b1, 1'b0));
    // bytes above 127 are not folded
    add_row(p_write(CfgCharsLow, 64'h0000_0000_0000_00E1));
    add_row(p_write(CfgLength, 64'd1));
    add_row(p_item(8'hC1, 1'b1, 1'b0));
    add_row(p_item(8'hE1, 1'b1, 1'b0));
    // all stars with an oversized length, clamped to the maximum
    add_row(p_write(CfgCharsHigh, 64'h2A2A_2A2A_2A2A_2A2A));
    add_row(p_write(CfgCharsLow, 64'h2A2A_2A2A_2A2A_2A2A));
    add_row(p_write(CfgLength, 64'd31));
    add_row(p_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
    add_row(p_item(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1));
    // a register write drops the name in progress
    add_row(p_item(8'h41, 1'b0, 1'b0));
    add_row(p_write(CfgCharsLow, 64'h0000_0000_0000_0042));
    add_row(p_write(CfgLength, 64'd1));
    add_row(p_item(8'h62, 1'b1, 1'b0));
    add_row(p_write(CfgUnused, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(p_item(8'h42, 1'b1, 1'b0));
    add_row(p_write(CfgCharsLow, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(p_write(CfgCharsHigh, 64'h0000_0000_0000_0000));
    add_row(p_write(CfgLength, 64'd16));
    add_row(p_item(8'hFF, 1'b1, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].idx, plan[i].wdata);
      else send_item(plan[i].it, plan[i].known, plan[i].want);
    end

    start_items = n_items;
    while (n_items - start_items < RandItems) begin
      new_pattern();
      repeat ($urandom_range(3, 10)) begin
        if (n_items - start_items >= RandItems) break;
        calm = (n_items - start_items >= RandItems - CalmItems);
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          send_item(in_item_t'{name_char: rand_char(),
                               end_of_name: 1'($urandom_range(0, 1)), empty_name: 1'b1});
        end else if (kind < 5) begin
          send_name(1'b0, 1'b1, 1'b0);
        end else begin
          send_name(kind < 9, 1'b0, 1'b0);
        end
      end
      // unfinished name, dropped by the next register write
      if ($urandom_range(0, 9) == 0) send_name(1'b0, 1'b0, 1'b1);
    end
    name_if.valid <= 1'b0;

    while (match_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d name transactions and %0d register writes over %0d random patterns",
             n_items, n_writes, n_phases);
    $display("compared %0d match results against the glob predictor", n_results);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
